@@ hdl/asc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg
// Shared widths, register map and mode codes of the sample conditioner.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 10;
  localparam int MODE_W   = 3;
  localparam int LEN_W    = 9;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  // register index, byte address = 4 * index
  localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAP_LOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAP_HIGH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLD_BAND = 3'd4;

  localparam logic [MODE_W-1:0] MODE_EMA      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WIN_AVG  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WIN_MAX  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD_AVG = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOLD_MAX = 3'd4;

  localparam logic [MODE_W-1:0]  RST_MODE      = MODE_EMA;
  localparam logic [LEVEL_W-1:0] RST_MAP_LOW   = 10'd0;
  localparam logic [LEVEL_W-1:0] RST_MAP_HIGH  = 10'd100;
  localparam logic [LEN_W-1:0]   RST_WINDOW    = 9'd1;
  localparam logic [LEVEL_W-1:0] RST_HOLD_BAND = 10'd0;

endpackage

`default_nettype wire

@@ hdl/asc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_sample_if / asc_result_if
// Valid/ready channels for raw samples and for conditioned results.
// ----------------------------------------------------------------------------
interface asc_sample_if
  import asc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface asc_result_if
  import asc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  level;
  logic [SAMPLE_W-1:0] raw_level;

  modport source (output valid, output level, output raw_level, input ready);
  modport sink   (input valid, input level, input raw_level, output ready);
endinterface

`default_nettype wire

@@ hdl/asc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_div
// Restoring divider, one quotient bit per cycle. Forms the window average
// from the window sum and the window length.
// ----------------------------------------------------------------------------
module asc_div #(
  parameter int DW = 23,
  parameter int VW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               done
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          fits;

  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    diff   = rem_sh - {1'b0, dvs};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign quotient = quo;

  // a pulse of done closes exactly one run
  assert property (@(posedge clk) disable iff (rst) done |-> !run && $past(run))
    else $error("asc_div: done without a finished run");
  assert property (@(posedge clk) disable iff (rst) run |-> cnt != '0)
    else $error("asc_div: running with an empty count");
  assert property (@(posedge clk) disable iff (rst) start |=> run)
    else $error("asc_div: start did not launch a run");

endmodule

`default_nettype wire

@@ hdl/adc_sample_conditioner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sample_conditioner
// EMA / window average / window max of raw samples, mapped to a level range
// with optional hold band; a bit-serial divider forms the window average.
// ----------------------------------------------------------------------------
// Flow: EMA, window max and held max items pass from accept through product,
//   reciprocal scale, clamp, and hold in the hold modes; held max gives a result only at window end.
// Items that close a window average first pass a bit-serial divide; other
//   window samples are only accumulated. No sample is accepted while an item
//   is in work. A result waiting on the output stalls the next.
// Reset (synchronous): registers to reset values; filter, hold, window cleared.
module adc_sample_conditioner
  import asc_pkg::*;
#(
  parameter int ADC_MAX       = 4095,
  parameter int WINDOW_MAX    = 256,
  parameter int EMA_FRAC_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  asc_sample_if.sink             sample_ch,
  asc_result_if.source           result_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int SPAN_W = LEVEL_W + 1;
  localparam int PW     = SAMPLE_W + SPAN_W;
  localparam int LW     = $clog2(WINDOW_MAX + 1);
  localparam int SUMW   = SAMPLE_W + LW;
  localparam int EW     = SAMPLE_W + EMA_FRAC_BITS;
  // divide by ADC_MAX as a multiply by the rounded-up reciprocal, exact for
  // every PW-bit product
  localparam int RK     = PW + $clog2(ADC_MAX);
  localparam int RW     = PW + 2;
  localparam logic [63:0] RECIP = ((64'd1 << RK) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_WAIT,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_POST
  } state_t;

  // configuration registers
  logic [MODE_W-1:0]  mode;
  logic [LEVEL_W-1:0] map_low;
  logic [LEVEL_W-1:0] map_high;
  logic [LEN_W-1:0]   window_len;
  logic [LEVEL_W-1:0] hold_band;

  logic [IDX_W-1:0]   cfg_idx;
  logic               cfg_wr;
  logic               cfg_clr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_clr = cfg_wr && (cfg_idx == REG_MODE || cfg_idx == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= RST_MODE;
      map_low    <= RST_MAP_LOW;
      map_high   <= RST_MAP_HIGH;
      window_len <= RST_WINDOW;
      hold_band  <= RST_HOLD_BAND;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:      mode       <= pwdata[MODE_W-1:0];
        REG_MAP_LOW:   map_low    <= pwdata[LEVEL_W-1:0];
        REG_MAP_HIGH:  map_high   <= pwdata[LEVEL_W-1:0];
        REG_WINDOW:    window_len <= pwdata[LEN_W-1:0];
        REG_HOLD_BAND: hold_band  <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:      prdata = DATA_W'(mode);
      REG_MAP_LOW:   prdata = DATA_W'(map_low);
      REG_MAP_HIGH:  prdata = DATA_W'(map_high);
      REG_WINDOW:    prdata = DATA_W'(window_len);
      REG_HOLD_BAND: prdata = DATA_W'(hold_band);
      default:       prdata = '0;
    endcase
  end

  // effective window length: zero counts as one, saturates at WINDOW_MAX
  logic [31:0]   len_sat;
  logic [LW-1:0] eff_len;

  always_comb begin
    if (window_len == '0) begin
      len_sat = 32'd1;
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      len_sat = 32'(WINDOW_MAX);
    end else begin
      len_sat = 32'(window_len);
    end
    eff_len = len_sat[LW-1:0];
  end

  // datapath state
  state_t              state;
  logic [EW-1:0]       ema_value;
  logic                ema_valid;
  logic [LEVEL_W-1:0]  last_level;
  logic                last_valid;
  logic [LW-1:0]       window_count;
  logic [SUMW-1:0]     window_sum;
  logic [SAMPLE_W-1:0] window_peak;
  logic [SAMPLE_W-1:0] val;
  logic                out_valid;
  logic [LEVEL_W-1:0]  out_level;
  logic [SAMPLE_W-1:0] out_raw;

  logic                accept;
  logic [SAMPLE_W-1:0] s;

  assign sample_ch.ready = (state == ST_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign s               = sample_ch.sample;

  assign result_ch.valid     = out_valid;
  assign result_ch.level     = out_level;
  assign result_ch.raw_level = out_raw;

  // EMA step: (3*ema + sample<<F) >> 2, first sample loads directly
  logic [EW-1:0]   ema_sq;
  logic [EW+1:0]   ema_sum;
  logic [EW-1:0]   ema_next;

  always_comb begin
    ema_sq   = EW'(s) << EMA_FRAC_BITS;
    ema_sum  = (EW+2)'({ema_value, 1'b0}) + (EW+2)'(ema_value) + (EW+2)'(ema_sq);
    ema_next = ema_valid ? ema_sum[EW+1:2] : ema_sq;
  end

  // window accumulation at accept (average and max modes)
  logic [SUMW-1:0]     sum_next;
  logic [SAMPLE_W-1:0] peak_next;
  logic [LW-1:0]       count_next;
  logic                win_full;

  always_comb begin
    sum_next   = window_sum + SUMW'(s);
    peak_next  = (s > window_peak) ? s : window_peak;
    count_next = window_count + LW'(1);
    win_full   = (count_next >= eff_len);
  end

  // window average divider and mapping product
  logic                div_start;
  logic [SUMW-1:0]     div_dividend;
  logic [LW-1:0]       div_divisor;
  logic [SUMW-1:0]     div_quo;
  logic                div_done;
  logic [SPAN_W-1:0]   span;
  logic [PW-1:0]       product;
  logic [PW-1:0]       prod_r;
  logic [PW+RW-1:0]    recip_prod;
  logic [PW-1:0]       map_q;
  logic                avg_go;

  always_comb begin
    span       = {1'b0, map_high} - {1'b0, map_low} + SPAN_W'(1);
    product    = PW'(val) * PW'(span);
    recip_prod = (PW+RW)'(prod_r) * (PW+RW)'(RECIP[RW-1:0]);
    avg_go     = accept && win_full &&
                 (mode == MODE_WIN_AVG || mode == MODE_HOLD_AVG);
    div_start    = avg_go;
    div_dividend = sum_next;
    div_divisor  = eff_len;
  end

  asc_div #(
    .DW (SUMW),
    .VW (LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // mapping, clamp and hold rule
  logic [PW:0]         qsum;
  logic [LEVEL_W-1:0]  mapped;
  logic [LEVEL_W-1:0]  diff;
  logic                keep;
  logic [LEVEL_W-1:0]  held;
  logic [SAMPLE_W-1:0] peak_held;
  logic                out_free;
  logic                hmax_full;

  always_comb begin
    qsum = (PW+1)'(map_q) + (PW+1)'(map_low);
    if (map_high < map_low) begin
      mapped = map_high;
    end else if (qsum > (PW+1)'(map_high)) begin
      mapped = map_high;
    end else begin
      mapped = qsum[LEVEL_W-1:0];
    end
    diff      = (mapped > last_level) ? mapped - last_level : last_level - mapped;
    keep      = last_valid && (diff <= hold_band);
    held      = keep ? last_level : mapped;
    peak_held = (SAMPLE_W'(held) > window_peak) ? SAMPLE_W'(held) : window_peak;
    hmax_full = (count_next >= eff_len);
    out_free  = !out_valid || result_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ema_value    <= '0;
      ema_valid    <= 1'b0;
      last_level   <= '0;
      last_valid   <= 1'b0;
      window_count <= '0;
      window_sum   <= '0;
      window_peak  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_EMA: begin
                ema_value <= ema_next;
                ema_valid <= 1'b1;
                val       <= ema_next[EW-1:EMA_FRAC_BITS];
                state     <= ST_MAP_GO;
              end
              MODE_WIN_AVG, MODE_WIN_MAX, MODE_HOLD_AVG: begin
                if (win_full) begin
                  window_count <= '0;
                  window_sum   <= '0;
                  window_peak  <= '0;
                  if (mode == MODE_WIN_MAX) begin
                    val   <= peak_next;
                    state <= ST_MAP_GO;
                  end else begin
                    state <= ST_AVG_WAIT;
                  end
                end else begin
                  window_count <= count_next;
                  window_sum   <= sum_next;
                  window_peak  <= peak_next;
                end
              end
              MODE_HOLD_MAX: begin
                val   <= s;
                state <= ST_MAP_GO;
              end
              default: ;
            endcase
          end
        end
        ST_AVG_WAIT: begin
          if (div_done) begin
            val   <= div_quo[SAMPLE_W-1:0];
            state <= ST_MAP_GO;
          end
        end
        ST_MAP_GO: begin
          prod_r <= product;
          state  <= ST_MAP_WAIT;
        end
        ST_MAP_WAIT: begin
          map_q <= PW'(recip_prod >> RK);
          state <= ST_POST;
        end
        ST_POST: begin
          if (out_free) begin
            state <= ST_IDLE;
            case (mode)
              MODE_EMA: begin
                last_level <= mapped;
                last_valid <= 1'b1;
                out_valid  <= 1'b1;
                out_level  <= mapped;
                out_raw    <= val;
              end
              MODE_HOLD_AVG: begin
                last_level <= held;
                last_valid <= 1'b1;
                out_valid  <= 1'b1;
                out_level  <= held;
                out_raw    <= val;
              end
              MODE_HOLD_MAX: begin
                last_level <= held;
                last_valid <= 1'b1;
                if (hmax_full) begin
                  window_count <= '0;
                  window_sum   <= '0;
                  window_peak  <= '0;
                  out_valid    <= 1'b1;
                  out_level    <= peak_held[LEVEL_W-1:0];
                  out_raw      <= '0;
                end else begin
                  window_count <= count_next;
                  window_peak  <= peak_held;
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_level <= mapped;
                out_raw   <= val;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_clr) begin
        window_count <= '0;
        window_sum   <= '0;
        window_peak  <= '0;
      end
    end
  end

  // divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_AVG_WAIT))
    else $error("asc: divider finished outside the wait state");
  assert property (@(posedge clk) disable iff (rst)
    window_count < eff_len || window_count == '0)
    else $error("asc: window count ran past the window length");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && out_free && mode != MODE_HOLD_MAX) |=> out_valid)
    else $error("asc: finished item not presented");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAP_GO) |=> state == ST_MAP_WAIT)
    else $error("asc: mapping product not passed to the scale step");

endmodule

`default_nettype wire
